@@ rtl/ipc_pkg.sv @@
package ipc_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	localparam logic [CFG_DATA_W-1:0] RESET_SIZE = 11'd1024;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	// position flags of one pixel, worked out when it is taken in
	typedef struct packed {
		logic first_row;
		logic first_col;
		logic row_end;
		logic frame_end;
	} pos_t;

	// line store update from the evaluation stage
	typedef struct packed {
		logic adv;
		logic prev_en;
		logic prev_bit;
		logic cur_en;
		logic cur_bit;
		logic up_bit;
	} wr_t;

endpackage

@@ rtl/isolated_pixel_check_top.sv @@
// Checks a binary frame, fed one pixel per word in raster order, for set
// pixels with no set up, down, left or right neighbour; pixels outside the
// frame count as clear. Frame size comes from the image_width and
// image_height registers (zero acts as one, values above MAX_WIDTH or
// MAX_HEIGHT act as the maximum). One pixel is taken every clock unless
// the input stalls; the verdict word is registered on the output as
// the frame's last pixel retires. Input stalls only when a frame's last
// pixel would overtake a verdict that has not been taken yet. The previous
// row lives in a one-bit line memory of MAX_WIDTH entries, and the open
// marks of set pixels still waiting for their lower neighbour in a second
// one split in even and odd column banks, so each pixel costs one read and
// at most one write per memory or bank in a cycle.
module isolated_pixel_check_top #(
	parameter int MAX_WIDTH  = ipc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = ipc_pkg::DEF_MAX_HEIGHT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ipc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ipc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           pixel,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           all_supported
);
	import ipc_pkg::*;

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic          adv;
	logic          valid_s1;
	logic          pixel_s1;
	pos_t          pos_s1;
	logic [AW-1:0] col_s1;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	wr_t           wr;
	logic          up_bit;
	logic          pend_bit;

	ipc_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel     (pixel),
		.adv       (adv),
		.valid_s1  (valid_s1),
		.pixel_s1  (pixel_s1),
		.pos_s1    (pos_s1),
		.col_s1    (col_s1),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr)
	);

	ipc_line_store #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.col_s1   (col_s1),
		.wr       (wr),
		.up_bit   (up_bit),
		.pend_bit (pend_bit)
	);

	ipc_eval u_eval (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_s1      (valid_s1),
		.pixel_s1      (pixel_s1),
		.pos_s1        (pos_s1),
		.up_bit        (up_bit),
		.pend_bit      (pend_bit),
		.out_stall     (out_stall),
		.adv           (adv),
		.wr            (wr),
		.out_valid     (out_valid),
		.all_supported (all_supported)
	);

`ifndef NO_ASSERTIONS
	a_verdict_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && pos_s1.frame_end && adv |=> out_valid)
		else $error("frame end retired without a verdict word");

	a_held_stage_stable: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(pixel_s1) && $stable(col_s1))
		else $error("held pixel stage changed");

	a_frame_end_ends_row: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && pos_s1.frame_end |-> pos_s1.row_end)
		else $error("frame end flagged mid-row");
`endif

endmodule

@@ rtl/ipc_front.sv @@
module ipc_front #(
	parameter int MAX_WIDTH  = ipc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = ipc_pkg::DEF_MAX_HEIGHT,
	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ipc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ipc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            pixel,
	input  logic                            adv,
	output logic                            valid_s1,
	output logic                            pixel_s1,
	output ipc_pkg::pos_t                   pos_s1,
	output logic [AW-1:0]                   col_s1,
	output logic                            rd_en,
	output logic [AW-1:0]                   rd_addr
);
	import ipc_pkg::*;

	localparam int SW = ($clog2(MAX_WIDTH + 1) > CFG_DATA_W) ? $clog2(MAX_WIDTH + 1) : CFG_DATA_W;
	localparam int HW = ($clog2(MAX_HEIGHT + 1) > CFG_DATA_W) ?
		$clog2(MAX_HEIGHT + 1) : CFG_DATA_W;
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	logic [CFG_DATA_W-1:0] width_q;
	logic [CFG_DATA_W-1:0] height_q;
	logic [AW-1:0]         col_q;
	logic [RW-1:0]         row_q;
	logic [SW-1:0]         w_eff;
	logic [HW-1:0]         h_eff;
	logic [SW:0]           col_next1;
	logic [HW:0]           row_next1;
	logic                  row_end;
	logic                  last_row;
	logic                  accept;
	pos_t                  pos;

	assign cfg_ready = 1'b1;

	// a size of zero acts as one, an oversized one as the maximum
	always_comb begin
		if (width_q == '0) begin
			w_eff = SW'(1);
		end else if (SW'(width_q) > SW'(MAX_WIDTH)) begin
			w_eff = SW'(MAX_WIDTH);
		end else begin
			w_eff = SW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = HW'(1);
		end else if (HW'(height_q) > HW'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(height_q);
		end
	end

	assign col_next1 = (SW + 1)'(col_q) + (SW + 1)'(1);
	assign row_next1 = (HW + 1)'(row_q) + (HW + 1)'(1);
	assign row_end   = col_next1 >= (SW + 1)'(w_eff);
	assign last_row  = row_next1 >= (HW + 1)'(h_eff);

	always_comb begin
		pos.first_row = (row_q == '0);
		pos.first_col = (col_q == '0);
		pos.row_end   = row_end;
		pos.frame_end = row_end && last_row;
	end

	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;
	assign rd_en    = accept;
	assign rd_addr  = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RESET_SIZE;
			height_q <= RESET_SIZE;
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_IMAGE_WIDTH:  width_q  <= cfg_data;
					REG_IMAGE_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				valid_s1 <= 1'b1;
				if (row_end) begin
					col_q <= '0;
					row_q <= last_row ? '0 : RW'(row_next1);
				end else begin
					col_q <= AW'(col_next1);
				end
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1 <= pixel;
			pos_s1   <= pos;
			col_s1   <= col_q;
		end
	end

endmodule

@@ rtl/ipc_line_store.sv @@
module ipc_line_store #(
	parameter int MAX_WIDTH = ipc_pkg::DEF_MAX_WIDTH,
	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	input  logic [AW-1:0] col_s1,
	input  ipc_pkg::wr_t  wr,
	output logic          up_bit,
	output logic          pend_bit
);
	import ipc_pkg::*;

	// pending marks are split into even and odd columns so that the marks of
	// the left column and of the row's last column can land in one cycle
	localparam int BD  = (MAX_WIDTH + 1) / 2;
	localparam int BAW = (BD > 1) ? $clog2(BD) : 1;

	logic upper_mem [MAX_WIDTH];
	logic pend_even [BD];
	logic pend_odd  [BD];

	logic [AW-1:0]  prev_addr;
	logic [BAW-1:0] cur_bank;
	logic [BAW-1:0] prev_bank;
	logic [BAW-1:0] rd_bank;
	logic           cur_even;
	logic           cur_odd;
	logic           even_we;
	logic           odd_we;
	logic [BAW-1:0] even_addr;
	logic [BAW-1:0] odd_addr;
	logic           even_d;
	logic           odd_d;

	logic           up_rd_q;
	logic           even_rd_q;
	logic           odd_rd_q;
	logic [AW-1:0]  rd_addr_q;
	logic           fwd_up_en_q;
	logic           fwd_cur_en_q;
	logic           fwd_prev_en_q;
	logic [AW-1:0]  fwd_cur_addr_q;
	logic [AW-1:0]  fwd_prev_addr_q;
	logic           fwd_up_q;
	logic           fwd_cur_q;
	logic           fwd_prev_q;

	assign prev_addr = col_s1 - AW'(1);
	assign cur_bank  = BAW'(col_s1 >> 1);
	assign prev_bank = BAW'(prev_addr >> 1);
	assign rd_bank   = BAW'(rd_addr >> 1);

	assign cur_even  = wr.cur_en && !col_s1[0];
	assign cur_odd   = wr.cur_en && col_s1[0];
	assign even_we   = wr.adv && (cur_even || (wr.prev_en && !prev_addr[0]));
	assign odd_we    = wr.adv && (cur_odd || (wr.prev_en && prev_addr[0]));
	assign even_addr = cur_even ? cur_bank : prev_bank;
	assign odd_addr  = cur_odd ? cur_bank : prev_bank;
	assign even_d    = cur_even ? wr.cur_bit : wr.prev_bit;
	assign odd_d     = cur_odd ? wr.cur_bit : wr.prev_bit;

	always_ff @(posedge clk) begin
		if (wr.adv) begin
			upper_mem[col_s1] <= wr.up_bit;
		end
		if (even_we) begin
			pend_even[even_addr] <= even_d;
		end
		if (odd_we) begin
			pend_odd[odd_addr] <= odd_d;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			up_rd_q         <= upper_mem[rd_addr];
			even_rd_q       <= pend_even[rd_bank];
			odd_rd_q        <= pend_odd[rd_bank];
			rd_addr_q       <= rd_addr;
			fwd_cur_addr_q  <= col_s1;
			fwd_prev_addr_q <= prev_addr;
			fwd_up_q        <= wr.up_bit;
			fwd_cur_q       <= wr.cur_bit;
			fwd_prev_q      <= wr.prev_bit;
		end
	end

	// remember what was written on the edge of the read; the read saw old data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_up_en_q   <= 1'b0;
			fwd_cur_en_q  <= 1'b0;
			fwd_prev_en_q <= 1'b0;
		end else if (rd_en) begin
			fwd_up_en_q   <= wr.adv;
			fwd_cur_en_q  <= wr.adv && wr.cur_en;
			fwd_prev_en_q <= wr.adv && wr.prev_en;
		end
	end

	always_comb begin
		up_bit = (fwd_up_en_q && fwd_cur_addr_q == rd_addr_q) ? fwd_up_q : up_rd_q;
		if (fwd_cur_en_q && fwd_cur_addr_q == rd_addr_q) begin
			pend_bit = fwd_cur_q;
		end else if (fwd_prev_en_q && fwd_prev_addr_q == rd_addr_q) begin
			pend_bit = fwd_prev_q;
		end else begin
			pend_bit = rd_addr_q[0] ? odd_rd_q : even_rd_q;
		end
	end

endmodule

@@ rtl/ipc_eval.sv @@
module ipc_eval (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid_s1,
	input  logic          pixel_s1,
	input  ipc_pkg::pos_t pos_s1,
	input  logic          up_bit,
	input  logic          pend_bit,
	input  logic          out_stall,
	output logic          adv,
	output ipc_pkg::wr_t  wr,
	output logic          out_valid,
	output logic          all_supported
);
	import ipc_pkg::*;

	logic left_pixel_q;
	logic left_pend_q;
	logic row_open_q;
	logic fail_q;
	logic out_valid_q;
	logic all_supported_q;

	logic up;
	logic up_pend;
	logic left;
	logic left_pend;
	logic fail_now;
	logic still;
	logic cur_pend;
	logic row_open_next;
	logic fail_row;

	// hold a frame's last pixel while the previous verdict waits
	assign adv = valid_s1 && !(pos_s1.frame_end && out_valid_q && out_stall);

	always_comb begin
		up            = pos_s1.first_row ? 1'b0 : up_bit;
		up_pend       = pos_s1.first_row ? 1'b0 : pend_bit;
		left          = pos_s1.first_col ? 1'b0 : left_pixel_q;
		left_pend     = pos_s1.first_col ? 1'b0 : left_pend_q;
		fail_now      = up_pend && !pixel_s1;
		still         = left_pend && !pixel_s1;
		cur_pend      = pixel_s1 && !up && !left;
		row_open_next = row_open_q || (!pos_s1.first_col && still)
			|| (pos_s1.row_end && cur_pend);
		fail_row      = fail_q || fail_now || (pos_s1.frame_end && row_open_next);
	end

	always_comb begin
		wr.adv      = adv;
		wr.prev_en  = !pos_s1.first_col;
		wr.prev_bit = still;
		wr.cur_en   = pos_s1.row_end;
		wr.cur_bit  = cur_pend;
		wr.up_bit   = pixel_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_pixel_q <= 1'b0;
			left_pend_q  <= 1'b0;
			row_open_q   <= 1'b0;
			fail_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (adv && pos_s1.frame_end) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (adv) begin
				if (pos_s1.row_end) begin
					left_pixel_q <= 1'b0;
					left_pend_q  <= 1'b0;
					row_open_q   <= 1'b0;
					if (pos_s1.frame_end) begin
						fail_q <= 1'b0;
					end else begin
						fail_q <= fail_row;
					end
				end else begin
					left_pixel_q <= pixel_s1;
					left_pend_q  <= cur_pend;
					row_open_q   <= row_open_next;
					fail_q       <= fail_q || fail_now;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && pos_s1.frame_end) begin
			all_supported_q <= !fail_row;
		end
	end

	assign out_valid     = out_valid_q;
	assign all_supported = all_supported_q;

endmodule

@@ tb/tb_isolated_pixel_check_top.sv @@
module tb_isolated_pixel_check_top;
	import ipc_pkg::*;

	localparam int unsigned MAX_W = DEF_MAX_WIDTH;
	localparam int unsigned MAX_H = DEF_MAX_HEIGHT;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
	localparam int DRAIN_CYCLES = 4;
	localparam int HOLD_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic pixel = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic all_supported;

	// pixel-level model of the checker
	logic [CFG_DATA_W-1:0] cfg_width = RESET_SIZE;
	logic [CFG_DATA_W-1:0] cfg_height = RESET_SIZE;
	bit line_px [MAX_W];
	bit open_mark [MAX_W];
	int unsigned col_pos = 0;
	int unsigned row_pos = 0;
	bit left_px = 1'b0;
	bit left_open = 1'b0;
	int unsigned row_open_cnt = 0;
	bit frame_failed = 1'b0;

	bit verdict_q [$];
	int errors = 0;
	int unsigned pixels_sent = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	bit hold_request = 1'b0;
	int hold_left = 0;

	isolated_pixel_check_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel(pixel),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.all_supported(all_supported)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic int unsigned eff_size(logic [CFG_DATA_W-1:0] v, int unsigned limit);
		if (v == 0)
			return 1;
		if (v > limit)
			return limit;
		return 32'(v);
	endfunction

	// returns 1 when the pixel closes the frame, with the verdict
	function automatic bit judge_pixel(bit p, output bit verdict);
		int unsigned w, h, c;
		bit first_row, first_col, row_end, frame_end;
		bit up, up_open, lft, lft_open, still, cur_open;
		w = eff_size(cfg_width, MAX_W);
		h = eff_size(cfg_height, MAX_H);
		c = col_pos % MAX_W;
		first_row = (row_pos == 0);
		first_col = (col_pos == 0);
		row_end = (col_pos + 1 >= w);
		frame_end = row_end && (row_pos + 1 >= h);
		up = first_row ? 1'b0 : line_px[c];
		up_open = first_row ? 1'b0 : open_mark[c];
		lft = first_col ? 1'b0 : left_px;
		lft_open = first_col ? 1'b0 : left_open;
		verdict = 1'b0;
		// pixel above now has all four neighbors known
		if (up_open && !p)
			frame_failed = 1'b1;
		// left pixel's right neighbor is known; carry its mark down
		if (!first_col) begin
			still = lft_open && !p;
			open_mark[(c + MAX_W - 1) % MAX_W] = still;
			if (still)
				row_open_cnt++;
		end
		cur_open = p && !up && !lft;
		line_px[c] = p;
		if (!row_end) begin
			left_px = p;
			left_open = cur_open;
			col_pos++;
			return 1'b0;
		end
		open_mark[c] = cur_open;
		if (cur_open)
			row_open_cnt++;
		if (frame_end && row_open_cnt != 0)
			frame_failed = 1'b1;
		left_px = 1'b0;
		left_open = 1'b0;
		row_open_cnt = 0;
		col_pos = 0;
		if (!frame_end) begin
			row_pos++;
			return 1'b0;
		end
		verdict = !frame_failed;
		row_pos = 0;
		frame_failed = 1'b0;
		return 1'b1;
	endfunction

	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (hold_request) begin
			out_stall <= 1'b1;
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// sample between edges; the word moves at the next rising edge
	always @(negedge clk) begin
		bit want;
		if (arst_n && out_valid && !out_stall) begin
			if (verdict_q.size() == 0) begin
				$display("%0t: unexpected verdict, expected none, actual %0b",
					$time, all_supported);
				errors++;
			end else begin
				want = verdict_q.pop_front();
				if (all_supported !== want) begin
					$display("%0t: all_supported mismatch, expected %0b, actual %0b",
						$time, want, all_supported);
					errors++;
				end
			end
		end
	end

	task automatic send_pixel(bit p);
		bit taken, verdict;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel <= p;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
		pixels_sent++;
		if (judge_pixel(p, verdict))
			verdict_q = {verdict_q, verdict};
	endtask

	task automatic send_bits(int n, logic [15:0] bits);
		for (int i = n - 1; i >= 0; i--)
			send_pixel(bits[i]);
	endtask

	// drop valid, wait for every verdict, then let the pipeline empty
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		bit done;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		done = 1'b0;
		while (!done) begin
			@(negedge clk);
			done = cfg_ready;
			@(posedge clk);
		end
		if (idx == REG_IMAGE_WIDTH)
			cfg_width = data;
		else if (idx == REG_IMAGE_HEIGHT)
			cfg_height = data;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_frame_size(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
	endtask

	// random frame; most get their lone pixels cleared, some then one bit flipped
	task automatic send_frame();
		int unsigned w, h, r, c, k, density;
		bit img [];
		w = eff_size(cfg_width, MAX_W);
		h = eff_size(cfg_height, MAX_H);
		img = new[w * h];
		density = $urandom_range(90, 15);
		for (k = 0; k < w * h; k++)
			img[k] = ($urandom_range(99) < density);
		if ($urandom_range(99) < 70) begin
			for (r = 0; r < h; r++) begin
				for (c = 0; c < w; c++) begin
					k = r * w + c;
					if (img[k] && !(r > 0 && img[k - w]) && !(r + 1 < h && img[k + w])
						&& !(c > 0 && img[k - 1]) && !(c + 1 < w && img[k + 1]))
						img[k] = 1'b0;
				end
			end
			if ($urandom_range(99) < 30) begin
				k = $urandom_range(w * h - 1);
				img[k] = !img[k];
			end
		end
		for (k = 0; k < w * h; k++)
			send_pixel(img[k]);
	endtask

	task automatic finish_frame();
		while (col_pos != 0 || row_pos != 0)
			send_pixel(1'($urandom_range(1)));
	endtask

	task automatic test_directed_corners();
		idle_pct = 0;
		stall_pct = 0;
		// zero sizes act as one pixel
		set_frame_size(11'd0, 11'd0);
		write_reg(REG_SPARE_A, 11'h7ff);
		write_reg(REG_SPARE_B, 11'h7ff);
		send_pixel(1'b1);
		send_pixel(1'b0);
		set_frame_size(11'd2, 11'd1);
		send_bits(2, 16'b11);
		send_bits(2, 16'b10);
		set_frame_size(11'd1, 11'd2);
		send_bits(2, 16'b11);
		send_bits(2, 16'b01);
		set_frame_size(11'd2, 11'd2);
		send_bits(4, 16'b1111);
		set_frame_size(11'd3, 11'd3);
		send_bits(9, 16'b100010001);
	endtask

	task automatic test_extreme_sizes();
		idle_pct = 0;
		stall_pct = 0;
		// oversized width clamps to the maximum
		set_frame_size(11'h7ff, 11'd1);
		send_frame();
	endtask

	task automatic test_midframe_writes();
		idle_pct = 0;
		stall_pct = 0;
		// shrink width past the current column in the second row
		set_frame_size(11'd8, 11'd4);
		repeat (13) send_pixel(1'($urandom_range(1)));
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, 11'd3);
		finish_frame();
		// shrink height below the current row
		set_frame_size(11'd4, 11'd6);
		repeat (10) send_pixel(1'($urandom_range(1)));
		wait_idle();
		write_reg(REG_IMAGE_HEIGHT, 11'd2);
		finish_frame();
		// widen while still in the first row
		set_frame_size(11'd3, 11'd3);
		repeat (2) send_pixel(1'($urandom_range(1)));
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, 11'd6);
		finish_frame();
	endtask

	task automatic test_input_backpressure();
		idle_pct = 0;
		stall_pct = 0;
		set_frame_size(11'd1, 11'd1);
		hold_request = 1'b1;
		repeat (40) send_pixel(1'($urandom_range(1)));
	endtask

	task automatic test_random_frames(int idle, int stall, int unsigned budget);
		int unsigned stop_at;
		logic [CFG_DATA_W-1:0] w, h;
		idle_pct = idle;
		stall_pct = stall;
		stop_at = pixels_sent + budget;
		while (pixels_sent < stop_at) begin
			if ($urandom_range(99) < 35) begin
				w = CFG_DATA_W'(($urandom_range(99) < 10) ?
					$urandom_range(64, 13) : $urandom_range(12, 1));
				h = CFG_DATA_W'($urandom_range(8, 1));
				if ($urandom_range(99) < 5)
					w = '0;
				if ($urandom_range(99) < 5)
					h = '0;
				set_frame_size(w, h);
			end
			send_frame();
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_corners();
		test_extreme_sizes();
		test_midframe_writes();
		test_input_backpressure();
		test_random_frames(0, 0, 60);
		test_random_frames(48, 0, 60);
		test_random_frames(0, 48, 60);
		test_random_frames(16, 16, 60);
		wait_idle();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
